>>> src/rate_monotonic_tick_scheduler_unit_assert.svh
// Assertion macros for the scheduler RTL
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_UNIT_ASSERT_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset
`define RMTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a result in the following cycle
`define RMTS_ASSERT_NEXT(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
    else $error(msg);

`endif

>>> src/rmts_pkg.sv
package rmts_pkg;

  localparam int MAX_TASKS = 4;
  localparam int TASK_W    = 2;
  localparam int VAL_W     = 16;
  localparam int TICK_W    = 32;
  localparam int CFG_IDX_W = 3;

  localparam int NUM_TASKS_DEF = 4;

  localparam logic [VAL_W-1:0] CNT_MAX = '1;

  // Request codes
  typedef enum logic {
    REQ_TICK   = 1'b0,
    REQ_REPORT = 1'b1
  } req_type_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_A = 3'd0,
    CFG_BUDGET_A = 3'd1,
    CFG_PERIOD_B = 3'd2,
    CFG_BUDGET_B = 3'd3,
    CFG_PERIOD_C = 3'd4,
    CFG_BUDGET_C = 3'd5,
    CFG_PERIOD_D = 3'd6,
    CFG_BUDGET_D = 3'd7
  } cfg_reg_t;

  localparam cfg_reg_t CFG_PERIOD_IDX [MAX_TASKS] =
    '{CFG_PERIOD_A, CFG_PERIOD_B, CFG_PERIOD_C, CFG_PERIOD_D};
  localparam cfg_reg_t CFG_BUDGET_IDX [MAX_TASKS] =
    '{CFG_BUDGET_A, CFG_BUDGET_B, CFG_BUDGET_C, CFG_BUDGET_D};

  // Best candidate so far, passed along the cell row
  typedef struct packed {
    logic              found;
    logic [VAL_W-1:0]  period;
    logic [TASK_W-1:0] idx;
  } sel_t;

  // Per-task status of the current tick
  typedef struct packed {
    logic             released;
    logic             missed;
    logic             finished;
    logic [VAL_W-1:0] miss_cnt;
    logic [VAL_W-1:0] done_cnt;
  } cell_stat_t;

  function automatic logic [VAL_W-1:0] sat_inc(input logic [VAL_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : VAL_W'(v + 1'b1);
  endfunction

endpackage

>>> src/rmts_cell.sv
module rmts_cell import rmts_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             period_we,
  input  logic             budget_we,
  input  logic [VAL_W-1:0] cfg_data,
  input  logic             tick_en,
  input  logic             run,
  input  sel_t             sel_in,
  output sel_t             sel_out,
  output cell_stat_t       stat
);

  logic [VAL_W-1:0] period_r, period_nxt;
  logic [VAL_W-1:0] budget_r, budget_nxt;
  logic [VAL_W-1:0] work_r, work_nxt;
  logic [VAL_W-1:0] phase_r, phase_nxt;
  logic [VAL_W-1:0] miss_r, miss_nxt;
  logic [VAL_W-1:0] done_r, done_nxt;

  logic             enabled;
  logic             release_now;
  logic             miss_now;
  logic [VAL_W-1:0] work_rel;
  logic             fin_now;

  // Release stage: reload work at phase zero, note a miss if work was left
  always_comb begin
    enabled     = (period_r != '0);
    release_now = enabled && (phase_r == '0);
    miss_now    = release_now && (work_r != '0);
    if (!enabled) begin
      work_rel = '0;
    end else if (release_now) begin
      work_rel = budget_r;
    end else begin
      work_rel = work_r;
    end
  end

  // Pass the shorter-period ready task on; ties keep the earlier cell
  always_comb begin
    sel_out = sel_in;
    if (enabled && (work_rel != '0) && (!sel_in.found || (period_r < sel_in.period))) begin
      sel_out.found  = 1'b1;
      sel_out.period = period_r;
      sel_out.idx    = TASK_W'(IDX);
    end
  end

  // Next state
  always_comb begin
    period_nxt = period_we ? cfg_data : period_r;
    budget_nxt = budget_we ? cfg_data : budget_r;
    fin_now    = run && (work_rel == VAL_W'(1));
    work_nxt   = work_r;
    phase_nxt  = phase_r;
    miss_nxt   = miss_r;
    done_nxt   = done_r;
    if (tick_en) begin
      work_nxt = run ? VAL_W'(work_rel - 1'b1) : work_rel;
      if (!enabled) begin
        phase_nxt = '0;
      end else if (release_now) begin
        phase_nxt = VAL_W'(period_r - 1'b1);
      end else begin
        phase_nxt = VAL_W'(phase_r - 1'b1);
      end
      if (miss_now) begin
        miss_nxt = sat_inc(miss_r);
      end
      if (fin_now) begin
        done_nxt = sat_inc(done_r);
      end
    end
  end

  always_comb begin
    stat.released = release_now;
    stat.missed   = miss_now;
    stat.finished = fin_now;
    stat.miss_cnt = miss_nxt;
    stat.done_cnt = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      budget_r <= '0;
      work_r   <= '0;
      phase_r  <= '0;
      miss_r   <= '0;
      done_r   <= '0;
    end else begin
      period_r <= period_nxt;
      budget_r <= budget_nxt;
      work_r   <= work_nxt;
      phase_r  <= phase_nxt;
      miss_r   <= miss_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

>>> src/rate_monotonic_tick_scheduler_unit.sv
// Rate-monotonic tick scheduler for up to NUM_TASKS periodic tasks. Each task is one cell in
// a row that holds its period, budget, remaining work, phase and saturating miss/completion
// counters; the best ready task (shortest period, lower index on ties) is found as the
// candidate passes down the row. One request, tick or report, is taken every clock cycle
// while the output register is free or being drained; its result appears in the output
// register in the cycle after the transfer, and a new request is taken in the same cycle
// that the waiting result is taken. Each result comes from one pass through the cell row.
module rate_monotonic_tick_scheduler_unit import rmts_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [TASK_W-1:0]    in_query_task,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TICK_W-1:0]    out_tick_number,
  output logic                 out_ran_valid,
  output logic [TASK_W-1:0]    out_ran_task,
  output logic                 out_finished,
  output logic [MAX_TASKS-1:0] out_released_mask,
  output logic [MAX_TASKS-1:0] out_missed_mask,
  output logic [VAL_W-1:0]     out_query_missed,
  output logic [VAL_W-1:0]     out_query_completed,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  logic                 accept;
  logic                 tick_en;
  sel_t                 sel [NUM_TASKS+1];
  cell_stat_t           stat [MAX_TASKS];
  logic [MAX_TASKS-1:0] run;

  logic [TICK_W-1:0]    tick_r, tick_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [TICK_W-1:0]    tick_num_r, tick_num_nxt;
  logic                 ran_valid_r, ran_valid_nxt;
  logic [TASK_W-1:0]    ran_task_r, ran_task_nxt;
  logic                 finished_r, finished_nxt;
  logic [MAX_TASKS-1:0] rel_mask_r, rel_mask_nxt;
  logic [MAX_TASKS-1:0] miss_mask_r, miss_mask_nxt;
  logic [VAL_W-1:0]     q_miss_r, q_miss_nxt;
  logic [VAL_W-1:0]     q_done_r, q_done_nxt;

  // Take a request whenever the output register is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign tick_en  = accept && (req_type_t'(in_req_type) == REQ_TICK);

  assign sel[0] = '0;

  // Row of task cells
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    if (i < NUM_TASKS) begin : g_used
      assign run[i] = tick_en && sel[NUM_TASKS].found && (sel[NUM_TASKS].idx == TASK_W'(i));
      rmts_cell #(
        .IDX (i)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .period_we (cfg_we && (cfg_reg_t'(cfg_index) == CFG_PERIOD_IDX[i])),
        .budget_we (cfg_we && (cfg_reg_t'(cfg_index) == CFG_BUDGET_IDX[i])),
        .cfg_data  (cfg_data),
        .tick_en   (tick_en),
        .run       (run[i]),
        .sel_in    (sel[i]),
        .sel_out   (sel[i+1]),
        .stat      (stat[i])
      );
    end else begin : g_unused
      assign run[i]  = 1'b0;
      assign stat[i] = '0;
    end
  end

  // Assemble the result of the transfer
  always_comb begin
    tick_nxt      = tick_en ? TICK_W'(tick_r + 1'b1) : tick_r;
    out_valid_nxt = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    tick_num_nxt  = tick_num_r;
    ran_valid_nxt = ran_valid_r;
    ran_task_nxt  = ran_task_r;
    finished_nxt  = finished_r;
    rel_mask_nxt  = rel_mask_r;
    miss_mask_nxt = miss_mask_r;
    q_miss_nxt    = q_miss_r;
    q_done_nxt    = q_done_r;
    if (accept) begin
      tick_num_nxt  = '0;
      ran_valid_nxt = 1'b0;
      ran_task_nxt  = '0;
      finished_nxt  = 1'b0;
      rel_mask_nxt  = '0;
      miss_mask_nxt = '0;
      if (tick_en) begin
        tick_num_nxt  = tick_r;
        ran_valid_nxt = sel[NUM_TASKS].found;
        ran_task_nxt  = sel[NUM_TASKS].found ? sel[NUM_TASKS].idx : '0;
        for (int k = 0; k < MAX_TASKS; k++) begin
          rel_mask_nxt[k]  = stat[k].released;
          miss_mask_nxt[k] = stat[k].missed;
          finished_nxt     = finished_nxt | stat[k].finished;
        end
      end
      if ({1'b0, in_query_task} < (TASK_W + 1)'(NUM_TASKS)) begin
        q_miss_nxt = stat[in_query_task].miss_cnt;
        q_done_nxt = stat[in_query_task].done_cnt;
      end else begin
        q_miss_nxt = '0;
        q_done_nxt = '0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    tick_num_r  <= tick_num_nxt;
    ran_valid_r <= ran_valid_nxt;
    ran_task_r  <= ran_task_nxt;
    finished_r  <= finished_nxt;
    rel_mask_r  <= rel_mask_nxt;
    miss_mask_r <= miss_mask_nxt;
    q_miss_r    <= q_miss_nxt;
    q_done_r    <= q_done_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_tick_number     = tick_num_r;
  assign out_ran_valid       = ran_valid_r;
  assign out_ran_task        = ran_task_r;
  assign out_finished        = finished_r;
  assign out_released_mask   = rel_mask_r;
  assign out_missed_mask     = miss_mask_r;
  assign out_query_missed    = q_miss_r;
  assign out_query_completed = q_done_r;

`include "rate_monotonic_tick_scheduler_unit_assert.svh"

  `RMTS_ASSERT(a_fin_needs_run, !out_valid_r || !finished_r || ran_valid_r, "finished without run")
  `RMTS_ASSERT(a_miss_in_release, !out_valid_r || ((miss_mask_r & ~rel_mask_r) == '0), "miss without release")
  `RMTS_ASSERT(a_stall_blocks_in, !(out_valid_r && !out_ready) || !in_ready, "accepted while output stalled")
  `RMTS_ASSERT_NEXT(a_tick_advance, rst_n && tick_en, tick_r == TICK_W'($past(tick_r) + 1'b1), "tick counter did not advance")

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rmts_pkg::*;

  // One scheduler response, as seen on the result channel
  typedef struct packed {
    logic [TICK_W-1:0]    tick_number;
    logic                 ran_valid;
    logic [TASK_W-1:0]    ran_task;
    logic                 finished;
    logic [MAX_TASKS-1:0] released_mask;
    logic [MAX_TASKS-1:0] missed_mask;
    logic [VAL_W-1:0]     query_missed;
    logic [VAL_W-1:0]     query_completed;
  } sched_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_req_type;
  logic [TASK_W-1:0]    in_query_task;
  logic                 out_valid;
  logic                 out_ready;
  logic [TICK_W-1:0]    out_tick_number;
  logic                 out_ran_valid;
  logic [TASK_W-1:0]    out_ran_task;
  logic                 out_finished;
  logic [MAX_TASKS-1:0] out_released_mask;
  logic [MAX_TASKS-1:0] out_missed_mask;
  logic [VAL_W-1:0]     out_query_missed;
  logic [VAL_W-1:0]     out_query_completed;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0]     cfg_data;

  // Shadow of the scheduler: configuration and per-task state
  logic [VAL_W-1:0]  task_period [MAX_TASKS];
  logic [VAL_W-1:0]  task_budget [MAX_TASKS];
  logic [VAL_W-1:0]  work_left   [MAX_TASKS];
  logic [VAL_W-1:0]  phase_left  [MAX_TASKS];
  logic [VAL_W-1:0]  miss_total  [MAX_TASKS];
  logic [VAL_W-1:0]  done_total  [MAX_TASKS];
  logic [TICK_W-1:0] tick_total;

  sched_result_t dispatch_q[$];
  int            mismatches;
  bit            tx_quiet;
  bit            rx_quiet;
  int            rx_stall;

  rate_monotonic_tick_scheduler_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_query_task       (in_query_task),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tick_number     (out_tick_number),
    .out_ran_valid       (out_ran_valid),
    .out_ran_task        (out_ran_task),
    .out_finished        (out_finished),
    .out_released_mask   (out_released_mask),
    .out_missed_mask     (out_missed_mask),
    .out_query_missed    (out_query_missed),
    .out_query_completed (out_query_completed),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [VAL_W-1:0] bump_sat(input logic [VAL_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Advance the shadow by one request and return the response it implies
  function automatic sched_result_t dispatch_step(input logic rt,
                                                  input logic [TASK_W-1:0] qt);
    sched_result_t r;
    int            best;
    int            i;
    r = '0;
    best = -1;
    if (rt == REQ_TICK) begin
      r.tick_number = tick_total;
      // release phase
      for (i = 0; i < MAX_TASKS; i++) begin
        if (task_period[i] == '0) begin
          work_left[i]  = '0;
          phase_left[i] = '0;
        end else if (phase_left[i] == '0) begin
          r.released_mask[i] = 1'b1;
          if (work_left[i] != '0) begin
            r.missed_mask[i] = 1'b1;
            miss_total[i]    = bump_sat(miss_total[i]);
          end
          work_left[i]  = task_budget[i];
          phase_left[i] = task_period[i] - 1'b1;
        end else begin
          phase_left[i] = phase_left[i] - 1'b1;
        end
      end
      // shortest period wins, lower index on ties
      for (i = 0; i < MAX_TASKS; i++) begin
        if (task_period[i] != '0 && work_left[i] != '0) begin
          if (best < 0 || task_period[i] < task_period[best]) best = i;
        end
      end
      if (best >= 0) begin
        r.ran_valid    = 1'b1;
        r.ran_task     = best[TASK_W-1:0];
        work_left[best] = work_left[best] - 1'b1;
        if (work_left[best] == '0) begin
          r.finished       = 1'b1;
          done_total[best] = bump_sat(done_total[best]);
        end
      end
      tick_total = tick_total + 1'b1;
    end
    r.query_missed    = miss_total[qt];
    r.query_completed = done_total[qt];
    return r;
  endfunction

  task automatic flag_field(input string fname, input logic [TICK_W-1:0] want_v,
                            input logic [TICK_W-1:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", fname, want_v, got_v);
    end
  endtask

  // Predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        dispatch_q.push_back(dispatch_step(in_req_type, in_query_task));
      end
      if (out_valid && out_ready) begin
        if (dispatch_q.size() == 0) begin
          mismatches++;
          $error("result transfer with no response outstanding");
        end else begin
          want = dispatch_q.pop_front();
          flag_field("tick_number", want.tick_number, out_tick_number);
          flag_field("ran_valid", TICK_W'(want.ran_valid), TICK_W'(out_ran_valid));
          flag_field("ran_task", TICK_W'(want.ran_task), TICK_W'(out_ran_task));
          flag_field("finished", TICK_W'(want.finished), TICK_W'(out_finished));
          flag_field("released_mask", TICK_W'(want.released_mask),
                     TICK_W'(out_released_mask));
          flag_field("missed_mask", TICK_W'(want.missed_mask),
                     TICK_W'(out_missed_mask));
          flag_field("query_missed", TICK_W'(want.query_missed),
                     TICK_W'(out_query_missed));
          flag_field("query_completed", TICK_W'(want.query_completed),
                     TICK_W'(out_query_completed));
        end
      end
    end
  end

  // Result side: random stalls unless held quiet
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall  <= rx_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!rx_quiet) rx_stall <= pick_gap();
    end
  end

  // Offer one request after a random gap and hold it until the transfer
  task automatic send_req(input req_type_t rt, input logic [TASK_W-1:0] qt);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= rt;
    in_query_task <= qt;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every outstanding response has been checked
  task automatic wait_quiescent();
    @(negedge clk);
    in_valid <= 1'b0;
    while (dispatch_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [VAL_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx[0]) begin
      task_budget[idx[CFG_IDX_W-1:1]] = val;
    end else begin
      task_period[idx[CFG_IDX_W-1:1]] = val;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Everything disabled right after reset: nothing is released or run
  task automatic test_reset_idle();
    send_req(REQ_TICK, 2'd0);
    send_req(REQ_TICK, 2'd3);
    send_req(REQ_REPORT, 2'd2);
    send_req(REQ_REPORT, 2'd1);
  endtask

  // Priority by period, a huge task, a disabled task with a budget
  task automatic test_priority_release();
    int k;
    wait_quiescent();
    write_reg(CFG_PERIOD_A, 16'd4);
    write_reg(CFG_BUDGET_A, 16'd2);
    write_reg(CFG_PERIOD_B, 16'd2);
    write_reg(CFG_BUDGET_B, 16'd1);
    write_reg(CFG_PERIOD_C, 16'hFFFF);
    write_reg(CFG_BUDGET_C, 16'hFFFF);
    write_reg(CFG_PERIOD_D, 16'd0);
    write_reg(CFG_BUDGET_D, 16'd7);
    for (k = 0; k < 8; k++) send_req(REQ_TICK, k[TASK_W-1:0]);
    send_req(REQ_REPORT, 2'd0);
    send_req(REQ_REPORT, 2'd2);
  endtask

  // Period changed mid-run, tied periods, zero budget, an overloaded task
  task automatic test_period_change_ties();
    int k;
    wait_quiescent();
    write_reg(CFG_PERIOD_B, 16'd4);
    write_reg(CFG_BUDGET_A, 16'd0);
    write_reg(CFG_PERIOD_D, 16'd1);
    write_reg(CFG_BUDGET_D, 16'd3);
    for (k = 0; k < 6; k++) send_req(REQ_TICK, 2'd3);
    send_req(REQ_REPORT, 2'd3);
  endtask

  // Full-rate overload: one task finishes every tick, its tied twin misses every tick
  task automatic test_full_rate_overload();
    int k;
    wait_quiescent();
    write_reg(CFG_PERIOD_A, 16'd1);
    write_reg(CFG_BUDGET_A, 16'd1);
    write_reg(CFG_PERIOD_B, 16'd1);
    write_reg(CFG_BUDGET_B, 16'd1);
    write_reg(CFG_PERIOD_C, 16'd0);
    write_reg(CFG_PERIOD_D, 16'd0);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    for (k = 0; k < 60; k++) send_req(REQ_TICK, TASK_W'($urandom_range(0, 3)));
    send_req(REQ_REPORT, 2'd0);
    send_req(REQ_REPORT, 2'd1);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] rand_period();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 18) return '1;
    if (roll < 28) return VAL_W'($urandom_range(0, 65535));
    return VAL_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [VAL_W-1:0] rand_budget();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 15) return '1;
    if (roll < 25) return VAL_W'($urandom_range(0, 65535));
    return VAL_W'($urandom_range(1, 4));
  endfunction

  // Phases of random requests, each under a fresh configuration (random from the third phase on)
  task automatic test_random_phases();
    int ph;
    int k;
    int t;
    req_type_t rt;
    for (ph = 0; ph < 10; ph++) begin
      wait_quiescent();
      for (t = 0; t < MAX_TASKS; t++) begin
        case (ph)
          0: begin
            write_reg(CFG_PERIOD_IDX[t], 16'd1);
            write_reg(CFG_BUDGET_IDX[t], '1);
          end
          1: begin
            write_reg(CFG_PERIOD_IDX[t], '1);
            write_reg(CFG_BUDGET_IDX[t], '0);
          end
          default: begin
            write_reg(CFG_PERIOD_IDX[t], rand_period());
            write_reg(CFG_BUDGET_IDX[t], rand_budget());
          end
        endcase
      end
      tx_quiet = (ph % 4 == 3);
      rx_quiet = (ph % 3 == 2);
      for (k = 0; k < 130; k++) begin
        // hold off until the pipeline is empty once mid-phase
        if (ph == 5 && k == 65) wait_quiescent();
        rt = ($urandom_range(0, 99) < 80) ? REQ_TICK : REQ_REPORT;
        send_req(rt, TASK_W'($urandom_range(0, 3)));
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    int t;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_TICK;
    in_query_task = '0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_PERIOD_A;
    cfg_data      = '0;
    mismatches    = 0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    tick_total    = '0;
    for (t = 0; t < MAX_TASKS; t++) begin
      task_period[t] = '0;
      task_budget[t] = '0;
      work_left[t]   = '0;
      phase_left[t]  = '0;
      miss_total[t]  = '0;
      done_total[t]  = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_idle();
    test_priority_release();
    test_period_change_ties();
    test_full_rate_overload();
    test_random_phases();

    wait_quiescent();
    if (mismatches == 0) begin
      $display("rate_monotonic_tick_scheduler_unit test passed");
    end else begin
      $display("rate_monotonic_tick_scheduler_unit test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("rate_monotonic_tick_scheduler_unit test failed");
    $finish;
  end

endmodule

>>> rate_monotonic_tick_scheduler_unit.f
+incdir+src
src/rmts_pkg.sv
src/rmts_cell.sv
src/rate_monotonic_tick_scheduler_unit.sv
test/tb_top.sv
